// ===== src/ogri_pkg.sv =====
package ogri_pkg;

    typedef enum logic [1:0] {
        OP_RAY   = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    localparam logic [2:0] REG_WIDTH  = 3'd0;
    localparam logic [2:0] REG_HEIGHT = 3'd1;
    localparam logic [2:0] REG_HIT    = 3'd2;
    localparam logic [2:0] REG_MISS   = 3'd3;
    localparam logic [2:0] REG_CLAMP  = 3'd4;
    localparam logic [2:0] REG_RADIUS = 3'd5;

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [15:0] start_x;
        logic signed [15:0] start_y;
        logic signed [15:0] end_x;
        logic signed [15:0] end_y;
        logic               is_obstacle;
    } req_t;

    typedef struct packed {
        logic               status;
        logic signed [15:0] cell_value;
        logic               cell_seen;
    } rsp_t;

    typedef struct packed {
        logic [8:0]         grid_width;
        logic [8:0]         grid_height;
        logic signed [15:0] hit_delta;
        logic signed [15:0] miss_delta;
        logic [14:0]        clamp_limit;
        logic [3:0]         disk_radius;
    } cfg_t;

endpackage

// ===== src/ogri_stream_if.sv =====
interface ogri_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== src/ogri_cfg_regs.sv =====
module ogri_cfg_regs
    import ogri_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);
    cfg_t        cfg_reg;
    logic [2:0]  idx;

    assign idx    = paddr[4:2];
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.grid_width  <= 9'd256;
            cfg_reg.grid_height <= 9'd256;
            cfg_reg.hit_delta   <= 16'sd217;
            cfg_reg.miss_delta  <= -16'sd104;
            cfg_reg.clamp_limit <= 15'd1280;
            cfg_reg.disk_radius <= 4'd0;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (idx)
                REG_WIDTH:  cfg_reg.grid_width  <= pwdata[8:0];
                REG_HEIGHT: cfg_reg.grid_height <= pwdata[8:0];
                REG_HIT:    cfg_reg.hit_delta   <= pwdata[15:0];
                REG_MISS:   cfg_reg.miss_delta  <= pwdata[15:0];
                REG_CLAMP:  cfg_reg.clamp_limit <= pwdata[14:0];
                REG_RADIUS: cfg_reg.disk_radius <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (idx)
            REG_WIDTH:  prdata = {23'd0, cfg_reg.grid_width};
            REG_HEIGHT: prdata = {23'd0, cfg_reg.grid_height};
            REG_HIT:    prdata = {{16{cfg_reg.hit_delta[15]}}, cfg_reg.hit_delta};
            REG_MISS:   prdata = {{16{cfg_reg.miss_delta[15]}}, cfg_reg.miss_delta};
            REG_CLAMP:  prdata = {17'd0, cfg_reg.clamp_limit};
            REG_RADIUS: prdata = {28'd0, cfg_reg.disk_radius};
            default:    prdata = '0;
        endcase
    end
endmodule

// ===== src/ogri_cell_unit.sv =====
// cell memory with a registered read port and a separate write port; the saturating add is done by the sequencer
module ogri_cell_unit
    import ogri_pkg::*;
#(
    parameter int ADDR_BITS = 16,
    parameter int LOG_ODDS_BITS = 16
)
(
    input  logic                            clk,
    input  logic                            rd_en,
    input  logic [ADDR_BITS-1:0]            rd_addr,
    input  logic                            wr_en,
    input  logic [ADDR_BITS-1:0]            wr_addr,
    input  logic signed [LOG_ODDS_BITS-1:0] wr_value,
    input  logic                            wr_seen,
    output logic signed [LOG_ODDS_BITS-1:0] rd_value,
    output logic                            rd_seen
);
    logic signed [LOG_ODDS_BITS-1:0] value_mem [2**ADDR_BITS];
    logic                            seen_mem [2**ADDR_BITS];
    logic signed [LOG_ODDS_BITS-1:0] value_q;
    logic                            seen_q;

    // every entry is zeroed by the clear pass that runs after reset
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            value_mem[wr_addr] <= wr_value;
            seen_mem[wr_addr]  <= wr_seen;
        end
        if (rd_en)
        begin
            value_q <= value_mem[rd_addr];
            seen_q  <= seen_mem[rd_addr];
        end
    end

    assign rd_value = value_q;
    assign rd_seen  = seen_q;
endmodule

// ===== src/ogri_sequencer.sv =====
module ogri_sequencer
    import ogri_pkg::*;
#(
    parameter int MAX_WIDTH = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int LOG_ODDS_BITS = 16,
    parameter int MAX_RADIUS = 15
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    ogri_stream_if.sink   req,
    ogri_stream_if.source rsp
);
    localparam int XB = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YB = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int AB = XB + YB;
    localparam int RB = $clog2(MAX_RADIUS + 2) + 1;
    localparam int LB = LOG_ODDS_BITS;
    localparam int SB = ((LB > 16) ? LB : 16) + 2;
    localparam logic signed [LB:0] LIM_MAX = (LB+1)'((64'd1 << (LB-1)) - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_CLEAR, S_WALK_RD, S_WALK_WAIT, S_WALK_WR,
        S_DISK_NEXT, S_DISK_RD, S_DISK_WAIT, S_DISK_WR, S_READ_RD, S_READ_WAIT, S_DONE
    } state_t;

    state_t state_reg;
    logic signed [17:0] x_reg, y_reg, x1_reg, y1_reg, dx_reg, dy_reg, err_reg;
    logic signed [17:0] sx_reg, sy_reg;
    logic signed [17:0] w_eff, h_eff;
    logic               obst_reg, hit_now_reg;
    logic               clr_req_reg;
    logic signed [RB:0] ddx_reg, ddy_reg, r_eff;
    logic [AB-1:0]      clr_reg;
    rsp_t               rsp_reg;
    logic               rsp_valid_reg;

    logic                  rd_en, wr_en, wr_seen;
    logic [AB-1:0]         rd_addr, wr_addr, addr_cur;
    logic signed [LB-1:0]  rd_value, wr_value;
    logic                  rd_seen;
    logic signed [LB:0]    lim;
    logic signed [SB-1:0]  sum;
    logic signed [17:0]    e2, cx, cy;
    logic                  cur_in;
    logic signed [2*RB+2:0] d2, r2;

    always_comb
    begin
        w_eff = (cfg.grid_width == 0) ? 18'sd1 :
                (32'(cfg.grid_width) > MAX_WIDTH) ? 18'(MAX_WIDTH) : 18'(cfg.grid_width);
        h_eff = (cfg.grid_height == 0) ? 18'sd1 :
                (32'(cfg.grid_height) > MAX_HEIGHT) ? 18'(MAX_HEIGHT) : 18'(cfg.grid_height);
        r_eff = (32'(cfg.disk_radius) > MAX_RADIUS) ? (RB+1)'(MAX_RADIUS)
                                                   : (RB+1)'(cfg.disk_radius);
        lim = (32'(cfg.clamp_limit) < 32'(LIM_MAX)) ? (LB+1)'(cfg.clamp_limit) : LIM_MAX;
        e2 = err_reg <<< 1;
        cx = (state_reg == S_DISK_RD || state_reg == S_DISK_WAIT || state_reg == S_DISK_WR)
             ? x1_reg + 18'(ddx_reg) : x_reg;
        cy = (state_reg == S_DISK_RD || state_reg == S_DISK_WAIT || state_reg == S_DISK_WR)
             ? y1_reg + 18'(ddy_reg) : y_reg;
        cur_in = (cx >= 0) && (cx < w_eff) && (cy >= 0) && (cy < h_eff);
        addr_cur = {cy[YB-1:0], cx[XB-1:0]};
        d2 = (2*RB+3)'(ddx_reg) * (2*RB+3)'(ddx_reg) + (2*RB+3)'(ddy_reg) * (2*RB+3)'(ddy_reg);
        r2 = (2*RB+3)'(r_eff) * (2*RB+3)'(r_eff);
        sum = SB'(rd_value) + (hit_now_reg ? SB'(cfg.hit_delta) : SB'(cfg.miss_delta));
        if (sum > SB'(lim)) sum = SB'(lim);
        if (sum < -SB'(lim)) sum = -SB'(lim);
        rd_en   = (state_reg == S_WALK_RD || state_reg == S_DISK_RD ||
                   state_reg == S_READ_RD);
        rd_addr = (state_reg == S_READ_RD) ? {y_reg[YB-1:0], x_reg[XB-1:0]} : addr_cur;
        wr_en   = (state_reg == S_WALK_WR && cur_in) ||
                  (state_reg == S_DISK_WR && cur_in && d2 <= r2) ||
                  (state_reg == S_CLEAR);
        wr_addr = (state_reg == S_CLEAR) ? clr_reg : addr_cur;
        wr_value = (state_reg == S_CLEAR) ? '0 : LB'(sum);
        wr_seen  = (state_reg != S_CLEAR);
    end

    ogri_cell_unit #(.ADDR_BITS(AB), .LOG_ODDS_BITS(LB)) u_cell (
        .clk, .rd_en, .rd_addr, .wr_en, .wr_addr, .wr_value, .wr_seen,
        .rd_value, .rd_seen
    );

    assign req.ready   = (state_reg == S_IDLE) && !rsp_valid_reg;
    assign rsp.valid   = rsp_valid_reg;
    assign rsp.payload = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            clr_req_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
            hit_now_reg   <= 1'b0;
            obst_reg      <= 1'b0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
                rsp_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req.valid && req.ready)
                    begin
                        logic signed [17:0] a, b, c, d, ce, de;
                        logic               in_a, in_c;
                        rsp_t               nr;
                        a = 18'(req.payload.start_x);
                        b = 18'(req.payload.start_y);
                        c = 18'(req.payload.end_x);
                        d = 18'(req.payload.end_y);
                        ce = (c < 0) ? 18'sd0 : (c >= w_eff) ? w_eff - 18'sd1 : c;
                        de = (d < 0) ? 18'sd0 : (d >= h_eff) ? h_eff - 18'sd1 : d;
                        in_a = (a >= 0 && a < w_eff && b >= 0 && b < h_eff);
                        in_c = (c >= 0 && c < w_eff && d >= 0 && d < h_eff);
                        nr = '0;
                        x_reg    <= a;
                        y_reg    <= b;
                        x1_reg   <= ce;
                        y1_reg   <= de;
                        dx_reg   <= (ce > a) ? ce - a : a - ce;
                        dy_reg   <= (de > b) ? de - b : b - de;
                        err_reg  <= ((ce > a) ? ce - a : a - ce) - ((de > b) ? de - b : b - de);
                        sx_reg   <= (a < ce) ? 18'sd1 : -18'sd1;
                        sy_reg   <= (b < de) ? 18'sd1 : -18'sd1;
                        obst_reg <= req.payload.is_obstacle;
                        hit_now_reg <= 1'b0;
                        unique case (op_t'(req.payload.operation))
                            OP_RAY:
                            begin
                                if (!in_a || (!in_c && !req.payload.is_obstacle))
                                begin
                                    nr.status = 1'b1;
                                    state_reg <= S_DONE;
                                end
                                else
                                    state_reg <= S_WALK_RD;
                            end
                            OP_READ:
                            begin
                                if (!in_a)
                                begin
                                    nr.status = 1'b1;
                                    state_reg <= S_DONE;
                                end
                                else
                                    state_reg <= S_READ_RD;
                            end
                            OP_CLEAR:
                            begin
                                clr_reg     <= '0;
                                clr_req_reg <= 1'b1;
                                state_reg   <= S_CLEAR;
                            end
                            default: state_reg <= S_DONE;
                        endcase
                        rsp_reg <= nr;
                    end
                end
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    // the pass after reset returns no result
                    if (clr_reg == '1)
                    begin
                        clr_req_reg <= 1'b0;
                        state_reg   <= clr_req_reg ? S_DONE : S_IDLE;
                    end
                end
                S_WALK_RD:
                begin
                    // end reached: obstacle gets the hit and then the disk, else finished
                    if (x_reg == x1_reg && y_reg == y1_reg)
                    begin
                        if (obst_reg && !hit_now_reg)
                        begin
                            hit_now_reg <= 1'b1;
                            state_reg   <= S_WALK_WAIT;
                        end
                        else if (obst_reg)
                        begin
                            ddx_reg   <= -r_eff;
                            ddy_reg   <= -r_eff;
                            state_reg <= S_DISK_NEXT;
                        end
                        else
                            state_reg <= S_DONE;
                    end
                    else
                        state_reg <= S_WALK_WAIT;
                end
                S_WALK_WAIT: state_reg <= S_WALK_WR;
                S_WALK_WR:
                begin
                    if (!(x_reg == x1_reg && y_reg == y1_reg))
                    begin
                        if (e2 > -dy_reg && e2 < dx_reg)
                        begin
                            err_reg <= err_reg - dy_reg + dx_reg;
                            x_reg <= x_reg + sx_reg;
                            y_reg <= y_reg + sy_reg;
                        end
                        else if (e2 > -dy_reg)
                        begin
                            err_reg <= err_reg - dy_reg;
                            x_reg <= x_reg + sx_reg;
                        end
                        else if (e2 < dx_reg)
                        begin
                            err_reg <= err_reg + dx_reg;
                            y_reg <= y_reg + sy_reg;
                        end
                    end
                    state_reg <= S_WALK_RD;
                end
                S_DISK_NEXT:
                begin
                    if (d2 <= r2)
                        state_reg <= S_DISK_RD;
                    else
                        state_reg <= S_DISK_WR;
                end
                S_DISK_RD:   state_reg <= S_DISK_WAIT;
                S_DISK_WAIT: state_reg <= S_DISK_WR;
                S_DISK_WR:
                begin
                    if (ddx_reg == r_eff)
                    begin
                        ddx_reg <= -r_eff;
                        if (ddy_reg == r_eff)
                            state_reg <= S_DONE;
                        else
                        begin
                            ddy_reg   <= ddy_reg + 1'b1;
                            state_reg <= S_DISK_NEXT;
                        end
                    end
                    else
                    begin
                        ddx_reg   <= ddx_reg + 1'b1;
                        state_reg <= S_DISK_NEXT;
                    end
                end
                S_READ_RD:   state_reg <= S_READ_WAIT;
                S_READ_WAIT:
                begin
                    rsp_reg.cell_value <= 16'(rd_value);
                    rsp_reg.cell_seen  <= rd_seen;
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    rsp_valid_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == S_CLEAR || cur_in))
        else $error("write outside grid");
    assert property (@(posedge clk) disable iff (!rst_n)
        req.ready |-> !rsp_valid_reg)
        else $error("ready while result pending");
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !rsp.ready) |=> rsp_valid_reg)
        else $error("result lost");
endmodule

// ===== src/occupancy_grid_ray_integrator.sv =====
// Log-odds occupancy grid updater. One request is taken at a time; ready is low
// while it runs. A ray takes each walked cell through read, wait and write states;
// for an obstacle, each cell of the (2r+1)^2 square is then tested, and one inside
// the radius is read, waited on and written back. A read passes through read and
// wait states. A clear, and the pass right after reset, sweep every entry of the
// cell memory (65536 at the defaults), during which no request is taken.
module occupancy_grid_ray_integrator
    import ogri_pkg::*;
#(
    parameter int MAX_WIDTH = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int LOG_ODDS_BITS = 16,
    parameter int MAX_RADIUS = 15
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    ogri_stream_if.sink   in_req,
    ogri_stream_if.source out_rsp
);
    cfg_t cfg;

    ogri_cfg_regs u_regs (
        .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
    );

    ogri_sequencer #(
        .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT),
        .LOG_ODDS_BITS(LOG_ODDS_BITS), .MAX_RADIUS(MAX_RADIUS)
    ) u_seq (
        .clk, .rst_n, .cfg, .req(in_req), .rsp(out_rsp)
    );
endmodule

// ===== dv/tb_occupancy_grid_ray_integrator.sv =====
`timescale 1ns / 100ps

module tb_occupancy_grid_ray_integrator;
    import ogri_pkg::*;

    localparam int GRID_MAX_W = 256;
    localparam int GRID_MAX_H = 256;
    localparam int RADIUS_CAP = 15;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    ogri_stream_if #(.payload_t(req_t)) req_ch ();
    ogri_stream_if #(.payload_t(rsp_t)) rsp_ch ();

    occupancy_grid_ray_integrator dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_req  (req_ch.sink),
        .out_rsp (rsp_ch.source)
    );

    // grid shadow and register shadow
    int                 cell_odds [GRID_MAX_W*GRID_MAX_H];
    bit                 cell_seen_map [GRID_MAX_W*GRID_MAX_H];
    logic [8:0]         width_reg;
    logic [8:0]         height_reg;
    logic signed [15:0] hit_reg;
    logic signed [15:0] miss_reg;
    logic [14:0]        clamp_reg;
    logic [3:0]         radius_reg;

    rsp_t pending_rsp [$];
    int   mismatches;
    int   send_idle_pct;
    int   recv_idle_pct;
    bit   recv_hold;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #20000000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic int grid_w();
        if (width_reg == 0) return 1;
        if (width_reg > GRID_MAX_W) return GRID_MAX_W;
        return width_reg;
    endfunction

    function automatic int grid_h();
        if (height_reg == 0) return 1;
        if (height_reg > GRID_MAX_H) return GRID_MAX_H;
        return height_reg;
    endfunction

    function automatic bit on_grid(int x, int y);
        return x >= 0 && x < grid_w() && y >= 0 && y < grid_h();
    endfunction

    function automatic void bump_cell(int x, int y, int delta);
        int lim;
        int v;
        int idx;
        if (!on_grid(x, y))
            return;
        lim = clamp_reg;
        idx = y * GRID_MAX_W + x;
        v = cell_odds[idx] + delta;
        if (v > lim) v = lim;
        if (v < -lim) v = -lim;
        cell_odds[idx] = v;
        cell_seen_map[idx] = 1'b1;
    endfunction

    function automatic void wipe_grid();
        foreach (cell_odds[i])
        begin
            cell_odds[i] = 0;
            cell_seen_map[i] = 1'b0;
        end
    endfunction

    // bresenham trace with misses before the end and, for an obstacle, hit at the end and over the disk
    function automatic void trace_ray(int x0, int y0, int x1, int y1, bit obstacle);
        int x, y, dx, dy, sx, sy, err, e2, r;
        x = x0;
        y = y0;
        dx = (x1 > x0) ? x1 - x0 : x0 - x1;
        dy = (y1 > y0) ? y1 - y0 : y0 - y1;
        sx = (x0 < x1) ? 1 : -1;
        sy = (y0 < y1) ? 1 : -1;
        err = dx - dy;
        while (!(x == x1 && y == y1))
        begin
            e2 = 2 * err;
            bump_cell(x, y, miss_reg);
            if (e2 > -dy)
            begin
                err -= dy;
                x += sx;
            end
            if (e2 < dx)
            begin
                err += dx;
                y += sy;
            end
        end
        if (obstacle)
        begin
            bump_cell(x1, y1, hit_reg);
            r = (radius_reg > RADIUS_CAP) ? RADIUS_CAP : radius_reg;
            for (int oy = -r; oy <= r; oy++)
                for (int ox = -r; ox <= r; ox++)
                    if (ox * ox + oy * oy <= r * r)
                        bump_cell(x1 + ox, y1 + oy, hit_reg);
        end
    endfunction

    function automatic rsp_t grid_response(req_t r);
        rsp_t o;
        int   x0, y0, x1, y1, idx;
        o = '0;
        x0 = r.start_x;
        y0 = r.start_y;
        x1 = r.end_x;
        y1 = r.end_y;
        case (op_t'(r.operation))
            OP_RAY:
            begin
                if (!on_grid(x0, y0) || (!on_grid(x1, y1) && !r.is_obstacle))
                    o.status = 1'b1;
                else
                begin
                    x1 = (x1 < 0) ? 0 : ((x1 > grid_w() - 1) ? grid_w() - 1 : x1);
                    y1 = (y1 < 0) ? 0 : ((y1 > grid_h() - 1) ? grid_h() - 1 : y1);
                    trace_ray(x0, y0, x1, y1, r.is_obstacle);
                end
            end
            OP_READ:
            begin
                if (!on_grid(x0, y0))
                    o.status = 1'b1;
                else
                begin
                    idx = y0 * GRID_MAX_W + x0;
                    o.cell_value = cell_odds[idx][15:0];
                    o.cell_seen = cell_seen_map[idx];
                end
            end
            OP_CLEAR: wipe_grid();
            default: ;
        endcase
        return o;
    endfunction

    task automatic send_request(req_t r);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid = 1'b0;
            @(negedge clk);
        end
        req_ch.valid = 1'b1;
        req_ch.payload = r;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        pending_rsp.push_back(grid_response(r));
    endtask

    task automatic drain();
        @(negedge clk);
        req_ch.valid = 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        drain();
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        case (idx)
            REG_WIDTH:  width_reg = value[8:0];
            REG_HEIGHT: height_reg = value[8:0];
            REG_HIT:    hit_reg = value[15:0];
            REG_MISS:   miss_reg = value[15:0];
            REG_CLAMP:  clamp_reg = value[14:0];
            REG_RADIUS: radius_reg = value[3:0];
            default: ;
        endcase
    endtask

    function automatic req_t make_req(op_t op, int sx, int sy, int ex, int ey, bit obs);
        req_t r;
        r.operation = op;
        r.start_x = sx[15:0];
        r.start_y = sy[15:0];
        r.end_x = ex[15:0];
        r.end_y = ey[15:0];
        r.is_obstacle = obs;
        return r;
    endfunction

    function automatic int pick_coord(int lim, bit keep_in);
        case ($urandom_range(keep_in ? 19 : 9))
            0: return $signed($urandom_range(65535) - 32768);
            1: return -$urandom_range(1, 3);
            2: return lim + $urandom_range(0, 3);
            default: return $urandom_range(lim - 1);
        endcase
    endfunction

    function automatic req_t random_req();
        int sel;
        sel = $urandom_range(99);
        if (sel < 4)
            return make_req(OP_NONE, $urandom, $urandom, $urandom, $urandom, $urandom);
        if (sel < 38)
            return make_req(OP_READ, pick_coord(grid_w(), 1), pick_coord(grid_h(), 1),
                            $urandom, $urandom, $urandom);
        return make_req(OP_RAY, pick_coord(grid_w(), 1), pick_coord(grid_h(), 1),
                        pick_coord(grid_w(), 0), pick_coord(grid_h(), 0), $urandom);
    endfunction

    task automatic clear_grid();
        send_request(make_req(OP_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom));
    endtask

    task automatic test_directed();
        write_reg(REG_WIDTH, 16);
        write_reg(REG_HEIGHT, 12);
        write_reg(REG_RADIUS, 2);
        send_request(make_req(OP_RAY, 0, 0, 15, 11, 1'b1));
        send_request(make_req(OP_RAY, 15, 11, 0, 0, 1'b0));
        send_request(make_req(OP_RAY, 3, 4, 3, 4, 1'b1));   // start on end
        send_request(make_req(OP_RAY, 3, 4, 3, 4, 1'b0));
        send_request(make_req(OP_RAY, -1, 2, 5, 5, 1'b1));  // start off grid
        send_request(make_req(OP_RAY, 16, 2, 5, 5, 1'b0));
        send_request(make_req(OP_RAY, 2, 2, 40, 5, 1'b0));  // free end off grid
        send_request(make_req(OP_RAY, 2, 2, 32767, -32768, 1'b1)); // end clamped
        send_request(make_req(OP_RAY, 8, 6, -32768, 32767, 1'b1));
        send_request(make_req(OP_RAY, 5, 5, 16, 12, 1'b1));  // upper edge clamp
        send_request(make_req(OP_READ, 15, 11, 0, 0, 1'b0));
        send_request(make_req(OP_READ, 0, 0, -1, -1, 1'b1));
        send_request(make_req(OP_READ, 3, 4, 0, 0, 1'b0));
        send_request(make_req(OP_READ, 10, 10, 0, 0, 1'b0)); // never touched
        send_request(make_req(OP_READ, 16, 0, 0, 0, 1'b0));
        send_request(make_req(OP_READ, -32768, 32767, 0, 0, 1'b0));
        send_request(make_req(OP_NONE, -1, -1, -1, -1, 1'b1));
        clear_grid();
        send_request(make_req(OP_READ, 15, 11, 0, 0, 1'b0));
        // size register zero and above maximum
        write_reg(REG_WIDTH, 0);
        write_reg(REG_HEIGHT, 9'h1FF);
        send_request(make_req(OP_RAY, 0, 255, 0, 0, 1'b1));
        send_request(make_req(OP_RAY, 1, 3, 0, 3, 1'b0));
        send_request(make_req(OP_READ, 0, 200, 0, 0, 1'b0));
        // saturation at both extremes
        write_reg(REG_WIDTH, 8);
        write_reg(REG_HEIGHT, 1);
        write_reg(REG_CLAMP, 15'h7FFF);
        write_reg(REG_HIT, 32'h7FFF);
        write_reg(REG_MISS, 32'hFFFF8000);
        write_reg(REG_RADIUS, 15);
        send_request(make_req(OP_RAY, 7, 0, 0, 0, 1'b1));
        send_request(make_req(OP_RAY, 0, 0, 7, 0, 1'b0));
        send_request(make_req(OP_READ, 0, 0, 0, 0, 1'b0));
        send_request(make_req(OP_READ, 3, 0, 0, 0, 1'b0));
        write_reg(REG_CLAMP, 0);
        send_request(make_req(OP_RAY, 0, 0, 7, 5, 1'b1));
        send_request(make_req(OP_READ, 7, 0, 0, 0, 1'b0));
    endtask

    task automatic test_random(int count, int w, int h, int hit, int miss, int clamp, int rad);
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        write_reg(REG_HIT, hit);
        write_reg(REG_MISS, miss);
        write_reg(REG_CLAMP, clamp);
        write_reg(REG_RADIUS, rad);
        repeat (count)
            send_request(random_req());
    endtask

    task automatic test_backpressure();
        recv_hold = 1'b1;
        fork
            begin
                repeat (600) @(posedge clk);
                recv_hold = 1'b0;
            end
        join_none
        repeat (20)
            send_request(random_req());
    endtask

    // receiver side
    always @(negedge clk)
        rsp_ch.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_rsp.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected response %p", rsp_ch.payload);
            end
            else if (rsp_ch.payload.status !== pending_rsp[0].status
                     || rsp_ch.payload.cell_value !== pending_rsp[0].cell_value
                     || rsp_ch.payload.cell_seen !== pending_rsp[0].cell_seen)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("response mismatch: expected %p actual %p",
                             pending_rsp[0], rsp_ch.payload);
                void'(pending_rsp.pop_front());
            end
            else
                void'(pending_rsp.pop_front());
        end
    end

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        req_ch.valid = 1'b0;
        req_ch.payload = '0;
        recv_hold = 1'b0;
        mismatches = 0;
        width_reg = 256;
        height_reg = 256;
        hit_reg = 217;
        miss_reg = -104;
        clamp_reg = 1280;
        radius_reg = 0;
        wipe_grid();
        send_idle_pct = 21;
        recv_idle_pct = 59;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random(190, 16, 8, 217, -104, 1280, 3);
        send_idle_pct = 59;
        recv_idle_pct = 21;
        clear_grid();
        test_random(170, 40, 33, 500, -300, 2000, 15);
        test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(160, 9, 21, -7000, 9000, 32767, 1);
        test_random(30, 256, 256, 32767, -32768, 30000, 0);
        drain();
        repeat (100) @(posedge clk);
        if (mismatches == 0 && pending_rsp.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
